// ===== hdl/lmep_pkg.sv =====
// ----------------------------------------------------------------------------
// lmep_pkg: shared types and helpers for the list-mode event buffer parser
// Result record layout, result kinds, header field masks and record builder.
// ----------------------------------------------------------------------------
package lmep_pkg;

	localparam int MAX_QDC_WORDS = 8;
	localparam int MIN_HDR_LEN   = 4;
	localparam int MAX_HDR_LEN   = 18;
	localparam int QDC_HDR_LEN   = 12;
	localparam int SAT_ENERGY    = 16383;
	localparam int CRATE_WEIGHT  = 100;

	localparam logic [31:0] HDR_LEN_MASK  = 32'h0001_F000;
	localparam logic [31:0] EVT_LEN_MASK  = 32'h7FFE_0000;
	localparam logic [31:0] CFD_MASK      = 32'h3FFF_0000;
	localparam logic [31:0] TRC_LEN_MASK  = 32'h7FFF_0000;
	localparam logic [31:0] LOW_HALF_MASK = 32'h0000_FFFF;

	localparam int TDATA_W = 144;

	// register indexes on the configuration write port
	localparam logic REG_STATS_LEN = 1'b0;
	localparam logic REG_NUM_QDCS  = 1'b1;

	typedef enum logic [2:0] {
		K_HEADER  = 3'd0,
		K_QDC     = 3'd1,
		K_TRACE   = 3'd2,
		K_BUF_ERR = 3'd3,
		K_STATS   = 3'd4,
		K_BAD_LEN = 3'd5,
		K_BAD_HDR = 3'd6
	} kind_t;

	// packed high to low so that channel lands in the lowest bits of tdata
	typedef struct packed {
		logic [31:0] value;
		logic [14:0] trace_length;
		logic [3:0]  flag_bits;
		logic [47:0] event_time;
		logic [13:0] cfd_time;
		logic [15:0] energy;
		logic [10:0] module_res;
		logic [3:0]  channel;
	} payload_t;

	typedef struct packed {
		kind_t    kind;
		logic     last;
		payload_t data;
	} rec_t;

	typedef struct packed {
		logic valid;  // at least one result to store
		logic two;    // a second result follows the first
	} push_t;

	function automatic rec_t make_rec(
		input kind_t       kind,
		input logic        full,
		input logic [31:0] w0,
		input logic [31:0] w1,
		input logic [31:0] w2,
		input logic [31:0] w3,
		input logic [7:0]  bmod,
		input logic [31:0] val,
		input logic        lst
	);
		rec_t        r;
		logic [31:0] cfd;
		logic [31:0] tl;
		r      = '0;
		r.kind = kind;
		r.last = lst;
		cfd    = (w2 & CFD_MASK) >> 16;
		tl     = (w3 & TRC_LEN_MASK) >> 16;
		if (kind != K_BUF_ERR) begin
			r.data.channel    = w0[3:0];
			r.data.module_res = {3'b0, bmod} + 11'(w0[11:8]) * 11'(CRATE_WEIGHT);
			if (full) begin
				r.data.energy       = w3[31] ? 16'(SAT_ENERGY) : w3[15:0];
				r.data.cfd_time     = cfd[13:0];
				r.data.event_time   = {w2[15:0], w1};
				r.data.flag_bits    = {w2[31], w2[30], w3[31], w0[31]};
				r.data.trace_length = tl[14:0];
				r.data.value        = val;
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/lmep_out_queue.sv =====
// ----------------------------------------------------------------------------
// lmep_out_queue: two-entry result queue
// Holds the results of one input word and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module lmep_out_queue import lmep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  rec_t  rec0,
	input  rec_t  rec1,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output rec_t  out_rec
);

	logic [1:0] cnt_q;
	rec_t       e0_q;
	rec_t       e1_q;
	logic       pop;

	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_rec   = e0_q;
	// space for two results once the head leaves
	assign in_ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push.valid) begin
			cnt_q <= push.two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			e0_q <= rec0;
			e1_q <= rec1;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> in_ready) else $error("push without room");
	a_two_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.two) |=> (cnt_q == 2'd2)) else $error("pair lost");
`endif

endmodule

// ===== hdl/list_mode_event_buffer_parser.sv =====
// ----------------------------------------------------------------------------
// list_mode_event_buffer_parser: digitizer list-mode buffer parser
// Splits raw buffer words into event header records, QDC words, trace samples
// and fault reports.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata[31:0] = data_word
// m_*       out  tvalid/tready      tdata[143:0], tuser[2:0] = kind, tlast = last
// wr_*      in   wr_en              wr_index selects register, wr_data value
//
// One raw word is accepted per cycle while the queue has room; its results are
// computed in the same cycle and land in a two-entry output queue. Header
// words give at most one beat, trace words give two. A word is taken while
// one result still waits if that result leaves in the same cycle, so a trace
// word waits until the previous pair has begun to leave. Reset clears all
// state; no clearing pass. Stalls on m_tready back up into s_tready.
// ----------------------------------------------------------------------------
module list_mode_event_buffer_parser import lmep_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// data_word
	input  logic [31:0]         s_tdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// channel, module_res, energy, cfd_time, event_time, flag_bits,
	// trace_length, value (lowest first)
	output logic [TDATA_W-1:0]  m_tdata,
	// kind
	output logic [2:0]          m_tuser,
	output logic                m_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  logic                wr_en,
	input  logic                wr_index,
	input  logic [4:0]          wr_data
);

	typedef enum logic [2:0] {
		P_WAIT_LEN,
		P_WAIT_MOD,
		P_HEADER,
		P_TRACE,
		P_SKIP,
		P_ABORT
	} phase_t;

	// config
	logic [4:0]  stats_len_q;
	logic [3:0]  num_qdcs_q;

	// parser state
	phase_t      phase_q, phase_d;
	logic [31:0] bwl_q, bwl_d;      // buffer words left
	logic [7:0]  bmod_q, bmod_d;    // buffer module
	logic [31:0] hdr_q [4];
	logic [4:0]  widx_q, widx_d;    // header word index
	logic [13:0] ewl_q, ewl_d;      // event words left to skip
	logic [14:0] samp_q, samp_d;    // trace samples left

	logic        acc;
	logic [31:0] w;
	logic [31:0] hv0, hv1, hv2, hv3; // header view with this word written
	logic [31:0] hl_x, el_x;
	logic [4:0]  hl;
	logic [13:0] el;
	logic [13:0] tw;
	logic [3:0]  q_clip;
	logic [3:0]  qn;
	logic        in_tail;          // buffer countdown applies this word
	logic [31:0] bwl_t;
	rec_t        r0, r1;
	push_t       push;
	logic        in_ready;
	rec_t        out_rec;

	assign w   = s_tdata;
	assign acc = s_tvalid && s_tready;
	assign s_tready = in_ready;

	assign hv0 = (phase_q == P_HEADER && widx_q == 5'd0) ? w : hdr_q[0];
	assign hv1 = (phase_q == P_HEADER && widx_q == 5'd1) ? w : hdr_q[1];
	assign hv2 = (phase_q == P_HEADER && widx_q == 5'd2) ? w : hdr_q[2];
	assign hv3 = (phase_q == P_HEADER && widx_q == 5'd3) ? w : hdr_q[3];

	assign hl_x   = (hv0 & HDR_LEN_MASK) >> 12;
	assign el_x   = (hv0 & EVT_LEN_MASK) >> 17;
	assign hl     = hl_x[4:0];
	assign el     = el_x[13:0];
	assign tw     = hv3[30:17];  // trace length / 2
	assign q_clip = (num_qdcs_q > 4'(MAX_QDC_WORDS)) ? 4'(MAX_QDC_WORDS) : num_qdcs_q;
	assign qn     = (hl >= 5'(QDC_HDR_LEN)) ? q_clip : 4'd0;

	always_comb begin
		phase_d   = phase_q;
		bwl_d     = bwl_q;
		bmod_d    = bmod_q;
		widx_d    = widx_q;
		ewl_d     = ewl_q;
		samp_d    = samp_q;
		r0        = '0;
		r1        = '0;
		push      = '0;
		in_tail   = 1'b0;
		bwl_t     = 32'd0;
		unique case (phase_q)
			P_WAIT_LEN: begin
				if (w == 32'd0) begin
					r0 = make_rec(K_BUF_ERR, 1'b0, hv0, hv1, hv2, hv3, bmod_q, 32'd0, 1'b1);
					push.valid = 1'b1;
				end else begin
					bwl_d   = w - 32'd1;
					phase_d = (bwl_d != 32'd0) ? P_WAIT_MOD : P_WAIT_LEN;
				end
			end
			P_WAIT_MOD: begin
				bmod_d = w[7:0];
				bwl_d  = bwl_q - 32'd1;
				if (bwl_d != 32'd0) begin
					phase_d = P_HEADER;
					widx_d  = 5'd0;
				end else begin
					phase_d = P_WAIT_LEN;
				end
			end
			P_HEADER: begin
				in_tail = 1'b1;
				if (widx_q == 5'd0) begin
					if (hl == stats_len_q) begin
						r0 = make_rec(K_STATS, 1'b0, hv0, hv1, hv2, hv3, bmod_q, 32'd0, 1'b1);
						push.valid = 1'b1;
						if (el > 14'd1) begin
							ewl_d   = el - 14'd1;
							phase_d = P_SKIP;
						end
					end else if (hl < 5'(MIN_HDR_LEN) || hl > 5'(MAX_HDR_LEN) || hl[0]) begin
						r0 = make_rec(K_BAD_HDR, 1'b0, hv0, hv1, hv2, hv3, bmod_q, 32'd0, 1'b1);
						push.valid = 1'b1;
						phase_d    = P_ABORT;
					end else begin
						widx_d = 5'd1;
					end
				end else if (widx_q < 5'd3) begin
					widx_d = widx_q + 5'd1;
				end else if (widx_q == 5'd3) begin
					push.valid = 1'b1;
					if (({1'b0, tw} + 15'(hl)) != {1'b0, el}) begin
						// length check failed: report and skip the rest
						r0 = make_rec(K_BAD_LEN, 1'b1, hv0, hv1, hv2, hv3, bmod_q, 32'd0, 1'b1);
						if (el > 14'd4) begin
							ewl_d   = el - 14'd4;
							phase_d = P_SKIP;
						end else begin
							widx_d = 5'd0;
						end
					end else begin
						r0 = make_rec(K_HEADER, 1'b1, hv0, hv1, hv2, hv3, bmod_q, 32'd0,
							(qn == 4'd0) && (tw == 14'd0));
						if (hl > 5'(MIN_HDR_LEN)) begin
							widx_d = 5'd4;
						end else if (tw != 14'd0) begin
							phase_d = P_TRACE;
							samp_d  = {tw, 1'b0};
						end else begin
							widx_d = 5'd0;
						end
					end
				end else begin
					// header words past word 3; the last qn of them are QDC sums
					if (qn != 4'd0 && widx_q >= (hl - {1'b0, qn})) begin
						r0 = make_rec(K_QDC, 1'b1, hv0, hv1, hv2, hv3, bmod_q, w,
							((widx_q + 5'd1) == hl) && (tw == 14'd0));
						push.valid = 1'b1;
					end
					widx_d = widx_q + 5'd1;
					if (widx_d >= hl) begin
						if (tw != 14'd0) begin
							phase_d = P_TRACE;
							samp_d  = {tw, 1'b0};
						end else begin
							widx_d = 5'd0;
						end
					end
				end
			end
			P_TRACE: begin
				in_tail = 1'b1;
				r0 = make_rec(K_TRACE, 1'b1, hv0, hv1, hv2, hv3, bmod_q,
					{16'd0, w[15:0]}, 1'b0);
				r1 = make_rec(K_TRACE, 1'b1, hv0, hv1, hv2, hv3, bmod_q,
					{16'd0, w[31:16]}, samp_q <= 15'd2);
				push.valid = 1'b1;
				push.two   = 1'b1;
				samp_d = (samp_q > 15'd2) ? samp_q - 15'd2 : 15'd0;
				if (samp_d == 15'd0) begin
					phase_d = P_HEADER;
					widx_d  = 5'd0;
				end
			end
			P_SKIP: begin
				in_tail = 1'b1;
				if (ewl_q > 14'd0) begin
					ewl_d = ewl_q - 14'd1;
				end
				if (ewl_d == 14'd0) begin
					phase_d = P_HEADER;
					widx_d  = 5'd0;
				end
			end
			P_ABORT: begin
				in_tail = 1'b1;
			end
			default: begin
				phase_d = P_WAIT_LEN;
			end
		endcase
		// buffer word countdown; at zero the next word is a length word
		if (in_tail) begin
			bwl_t = (bwl_q > 32'd0) ? bwl_q - 32'd1 : bwl_q;
			bwl_d = bwl_t;
			if (bwl_t == 32'd0) begin
				phase_d = P_WAIT_LEN;
			end
		end
		push.valid = push.valid && acc;
		push.two   = push.two && acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_len_q <= 5'd31;
			num_qdcs_q  <= 4'd8;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STATS_LEN: stats_len_q <= wr_data;
				REG_NUM_QDCS:  num_qdcs_q  <= wr_data[3:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_WAIT_LEN;
			bwl_q    <= 32'd0;
			bmod_q   <= 8'd0;
			widx_q   <= 5'd0;
			ewl_q    <= 14'd0;
			samp_q   <= 15'd0;
			hdr_q[0] <= 32'd0;
			hdr_q[1] <= 32'd0;
			hdr_q[2] <= 32'd0;
			hdr_q[3] <= 32'd0;
		end else if (acc) begin
			phase_q <= phase_d;
			bwl_q   <= bwl_d;
			bmod_q  <= bmod_d;
			widx_q  <= widx_d;
			ewl_q   <= ewl_d;
			samp_q  <= samp_d;
			if (phase_q == P_HEADER && widx_q < 5'd4) begin
				hdr_q[widx_q[1:0]] <= w;
			end
		end
	end

	lmep_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec0      (r0),
		.rec1      (r1),
		.in_ready  (in_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec)
	);

	assign m_tdata = out_rec.data;
	assign m_tuser = out_rec.kind;
	assign m_tlast = out_rec.last;

`ifndef SYNTHESIS
	a_trace_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == P_TRACE) |=> m_tvalid) else $error("trace beat missing");
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == K_BUF_ERR || m_tuser == K_STATS ||
		m_tuser == K_BAD_LEN || m_tuser == K_BAD_HDR)) |-> m_tlast)
		else $error("report beat without last");
	a_mod_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_WAIT_MOD) |-> (bwl_q != 32'd0)) else $error("module word past end");
	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		widx_q <= 5'(MAX_HDR_LEN)) else $error("header index out of range");
`endif

endmodule
